@@ rtl/deq_pkg.sv @@
package deq_pkg;

    // Operation requested by one item
    typedef enum logic [1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } deq_mode_t;

    // Outcome reported with every result
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    typedef struct packed {
        deq_mode_t                 mode;
        logic signed [WORD_W-1:0]  value;
    } deq_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  popped_value;
        deq_status_t               status;
        logic        [OCC_W-1:0]   occupancy;
    } deq_rsp_t;

endpackage

@@ rtl/double_ended_queue_top.sv @@
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------------
// req       | in        | req_valid/req_ready  | deq_req_t: mode, value
// rsp       | out       | rsp_valid/rsp_ready  | deq_rsp_t: popped_value, status, occupancy
//
// Up to one item per cycle is accepted while req_ready is high; every item yields one item
// on rsp, which passes through the pending stage and then the output register. The ring
// store is a synchronous RAM with one write and one read port; its registered read
// sets the pending stage before the output register. Reset clears the front
// index, the count and both valid flags; the store is not cleared. A stalled rsp holds
// the output register and then the pending stage, and req_ready drops only once both are full.
module double_ended_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  deq_pkg::deq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output deq_pkg::deq_rsp_t rsp
);
    import deq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = IDX_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);

    // Ring store
    logic [WORD_W-1:0] mem [CAPACITY];
    logic [WORD_W-1:0] rd_data_reg;

    // Queue state
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pending stage: waits for the read data
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_pop_reg;
    deq_status_t       pend_status_reg;
    logic [CNT_W-1:0]  pend_count_reg;

    // Output register
    logic              rsp_valid_reg, rsp_valid_next;
    deq_rsp_t          rsp_reg;

    logic              accept;
    logic              pend_advance;
    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic              is_pop;
    deq_status_t       status;
    logic [SUM_W-1:0]  back_sum, last_sum;
    logic [IDX_W-1:0]  back_idx, last_idx, prev_front, succ_front;

    // Handshake
    assign pend_advance = pend_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready    = !pend_valid_reg || pend_advance;
    assign accept       = req_valid && req_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

    // Ring index arithmetic: sums stay below twice the capacity (last_sum only when not empty)
    always_comb
    begin
        back_sum   = {1'b0, front_reg} + SUM_W'(count_reg);
        last_sum   = {1'b0, front_reg} + SUM_W'(count_reg - CNT_W'(1));
        back_idx   = (back_sum >= CAP_SUM) ? IDX_W'(back_sum - CAP_SUM)
                                           : back_sum[IDX_W-1:0];
        last_idx   = (last_sum >= CAP_SUM) ? IDX_W'(last_sum - CAP_SUM)
                                           : last_sum[IDX_W-1:0];
        prev_front = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
        succ_front = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);
    end

    // Operation decode and state update
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = back_idx;
        rd_addr    = front_reg;
        is_pop     = 1'b0;
        status     = ST_OK;
        unique case (req.mode)
            MODE_PUSH_BACK:
            begin
                if (count_reg == FULL_CNT)
                    status = ST_FULL;
                else
                begin
                    wr_en      = accept;
                    wr_addr    = back_idx;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_PUSH_FRONT:
            begin
                if (count_reg == FULL_CNT)
                    status = ST_FULL;
                else
                begin
                    wr_en      = accept;
                    wr_addr    = prev_front;
                    front_next = prev_front;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_POP_FRONT:
            begin
                is_pop = 1'b1;
                if (count_reg == '0)
                    status = ST_EMPTY;
                else
                begin
                    rd_en      = accept;
                    rd_addr    = front_reg;
                    front_next = succ_front;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_POP_BACK:
            begin
                is_pop = 1'b1;
                if (count_reg == '0)
                    status = ST_EMPTY;
                else
                begin
                    rd_en      = accept;
                    rd_addr    = last_idx;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Valid flags of the two stages
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
            pend_valid_next = 1'b1;
        else if (pend_advance)
            pend_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (pend_advance)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    // Memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= req.value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload of the pending stage and the output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_pop_reg    <= is_pop;
            pend_status_reg <= status;
            pend_count_reg  <= count_next;
        end
        if (pend_advance)
        begin
            rsp_reg.popped_value <= (pend_pop_reg && pend_status_reg == ST_OK)
                                    ? $signed(rd_data_reg) : '0;
            rsp_reg.status       <= pend_status_reg;
            rsp_reg.occupancy    <= OCC_W'(pend_count_reg);
        end
    end

endmodule
